FILE: design/tpeq_pkg.sv
// Shared types, constants and codes for the touch pad event qualifier.
package tpeq_pkg;

    // Pad count and the index width it needs
    localparam int NUM_PADS  = 10;
    localparam int PAD_IDX_W = (NUM_PADS > 1) ? $clog2(NUM_PADS) : 1;

    // Pad reading that carries no measurement
    localparam logic [15:0] NO_READING = 16'hFFFF;

    // Event kinds
    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_TOUCH   = 2'd1;
    localparam logic [1:0] KIND_REPEAT  = 2'd2;
    localparam logic [1:0] KIND_RELEASE = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] CFG_HOLD_DELAY    = 3'd0;
    localparam logic [2:0] CFG_REPEAT_PERIOD = 3'd1;
    localparam logic [2:0] CFG_TOUCH_LEVEL   = 3'd2;
    localparam logic [2:0] CFG_RELEASE_LEVEL = 3'd3;
    localparam logic [2:0] CFG_NOTIFY_ENABLE = 3'd4;

    // Input item
    typedef struct packed {
        logic [3:0]  pad_index;
        logic [15:0] reading;
        logic [31:0] now_ms;
    } in_item_t;

    // Result item
    typedef struct packed {
        logic [3:0]  event_pad;
        logic [1:0]  event_kind;
        logic [31:0] event_time;
        logic        threshold_write;
        logic [15:0] threshold_value;
    } out_item_t;

    // Shared settings
    typedef struct packed {
        logic [15:0] hold_delay_ms;
        logic [15:0] repeat_period_ms;
        logic [15:0] touch_level;
        logic [15:0] release_level;
        logic        notify_enable;
    } cfg_t;

    // Stored times of one pad
    typedef struct packed {
        logic [31:0] trigger_time;
        logic [31:0] first_touch_time;
    } pad_state_t;

    // Update of one pad's stored times
    typedef struct packed {
        logic        trigger_we;
        logic [31:0] trigger_time;
        logic        first_we;
        logic [31:0] first_touch_time;
    } pad_upd_t;

endpackage

FILE: design/tpeq_pad_state.sv
// Per-pad trigger and first-touch time table with one read and one write port.
module tpeq_pad_state (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [3:0]            pad_index,
    input  logic                  upd_en,
    input  tpeq_pkg::pad_upd_t    upd,
    output tpeq_pkg::pad_state_t  rd_state
);

    logic [31:0] trigger_reg [tpeq_pkg::NUM_PADS];
    logic [31:0] first_reg   [tpeq_pkg::NUM_PADS];

    logic                           pad_ok;
    logic [tpeq_pkg::PAD_IDX_W-1:0] idx;

    assign pad_ok = {1'b0, pad_index} < 5'(tpeq_pkg::NUM_PADS);
    assign idx    = tpeq_pkg::PAD_IDX_W'(pad_index);

    // Read the addressed pad; out of range reads as empty
    always_comb begin
        if (pad_ok) begin
            rd_state.trigger_time     = trigger_reg[idx];
            rd_state.first_touch_time = first_reg[idx];
        end else begin
            rd_state.trigger_time     = '0;
            rd_state.first_touch_time = '0;
        end
    end

    // Write back the addressed pad when the item advances
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int p = 0; p < tpeq_pkg::NUM_PADS; p++) begin
                trigger_reg[p] <= '0;
                first_reg[p]   <= '0;
            end
        end else if (upd_en && pad_ok) begin
            if (upd.trigger_we) begin
                trigger_reg[idx] <= upd.trigger_time;
            end
            if (upd.first_we) begin
                first_reg[idx] <= upd.first_touch_time;
            end
        end
    end

endmodule

FILE: design/tpeq_eval.sv
// Event decision for one pad reading: result fields and pad state update.
module tpeq_eval (
    input  tpeq_pkg::in_item_t    item,
    input  tpeq_pkg::pad_state_t  state,
    input  tpeq_pkg::cfg_t        cfg,
    output tpeq_pkg::out_item_t   result,
    output tpeq_pkg::pad_upd_t    upd
);

    logic        pad_ok;
    logic        trig_set;
    logic        first_set;
    logic [31:0] since_trig;
    logic [31:0] since_first;
    logic        repeat_due;
    logic        hold_due;
    logic [1:0]  kind;

    assign pad_ok      = {1'b0, item.pad_index} < 5'(tpeq_pkg::NUM_PADS);
    assign trig_set    = state.trigger_time != '0;
    assign first_set   = state.first_touch_time != '0;
    assign since_trig  = item.now_ms - state.trigger_time;
    assign since_first = item.now_ms - state.first_touch_time;
    assign repeat_due  = since_trig >= {16'd0, cfg.repeat_period_ms};
    assign hold_due    = since_first >= {16'd0, cfg.hold_delay_ms};

    // Decide the event and the state change
    always_comb begin
        kind                 = tpeq_pkg::KIND_NONE;
        upd                  = '0;
        result.threshold_write = 1'b0;
        result.threshold_value = '0;
        if (pad_ok && item.reading != tpeq_pkg::NO_READING) begin
            if (item.reading > cfg.release_level) begin
                // Released: drop pending touch, rearm threshold
                upd.first_we           = 1'b1;
                result.threshold_write = 1'b1;
                result.threshold_value = cfg.touch_level;
                if (trig_set) begin
                    upd.trigger_we = 1'b1;
                    kind           = tpeq_pkg::KIND_RELEASE;
                end
            end else if (cfg.repeat_period_ms != '0 || !trig_set) begin
                // Held: touch after delay, then repeat
                if (trig_set) begin
                    if (repeat_due) begin
                        upd.trigger_we   = 1'b1;
                        upd.trigger_time = item.now_ms;
                        kind             = tpeq_pkg::KIND_REPEAT;
                    end
                end else if (cfg.hold_delay_ms == '0) begin
                    upd.trigger_we   = 1'b1;
                    upd.trigger_time = item.now_ms;
                    kind             = tpeq_pkg::KIND_TOUCH;
                end else if (!first_set) begin
                    upd.first_we         = 1'b1;
                    upd.first_touch_time = item.now_ms;
                end else if (hold_due) begin
                    upd.trigger_we   = 1'b1;
                    upd.trigger_time = item.now_ms;
                    kind             = tpeq_pkg::KIND_TOUCH;
                end
                result.threshold_write = 1'b1;
                result.threshold_value = tpeq_pkg::NO_READING;
            end
            if (!cfg.notify_enable) begin
                kind = tpeq_pkg::KIND_NONE;
            end
        end
        result.event_pad  = item.pad_index;
        result.event_kind = kind;
        result.event_time = item.now_ms;
    end

endmodule

FILE: design/touch_pad_event_qualifier_unit.sv
// Top level of the touch pad event qualifier: item registers, settings and state table.
//
// Each accepted pad reading gives exactly one result item. The block takes one
// item per cycle while m_ready holds; m_ready low stalls it. An accepted item is
// held in the input register, then decided on and loaded into the result
// register once that register is free or its item is taken, and offered from
// there (input register, then result register). While a finished result waits
// to be taken, the input register can still take one more item; the input then
// stalls until the result leaves. The per-pad trigger and first-touch times are
// read, decided on and written back between the input and result registers, so
// consecutive readings of the same pad always see each other's updates. Settings
// are written through cfg_we, cfg_index and cfg_wdata; write them only while no
// item is in flight.
module touch_pad_event_qualifier_unit (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  tpeq_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output tpeq_pkg::out_item_t  m_data,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [15:0]          cfg_wdata
);

    tpeq_pkg::cfg_t       cfg_reg;
    logic                 in_valid_reg;
    tpeq_pkg::in_item_t   in_item_reg;
    logic                 out_valid_reg;
    tpeq_pkg::out_item_t  out_item_reg;
    tpeq_pkg::pad_state_t pad_state;
    tpeq_pkg::pad_upd_t   pad_upd;
    tpeq_pkg::out_item_t  result;
    logic                 advance;

    // Move the held item on when the result register is free
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_item_reg;

    // Settings registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{hold_delay_ms:    16'd0,
                         repeat_period_ms: 16'd0,
                         touch_level:      16'd0,
                         release_level:    16'd0,
                         notify_enable:    1'b1};
        end else if (cfg_we) begin
            unique case (cfg_index)
                tpeq_pkg::CFG_HOLD_DELAY:    cfg_reg.hold_delay_ms    <= cfg_wdata;
                tpeq_pkg::CFG_REPEAT_PERIOD: cfg_reg.repeat_period_ms <= cfg_wdata;
                tpeq_pkg::CFG_TOUCH_LEVEL:   cfg_reg.touch_level      <= cfg_wdata;
                tpeq_pkg::CFG_RELEASE_LEVEL: cfg_reg.release_level    <= cfg_wdata;
                tpeq_pkg::CFG_NOTIFY_ENABLE: cfg_reg.notify_enable    <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_item_reg <= result;
        end
    end

    tpeq_pad_state u_pad_state (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pad_index (in_item_reg.pad_index),
        .upd_en    (advance),
        .upd       (pad_upd),
        .rd_state  (pad_state)
    );

    tpeq_eval u_eval (
        .item   (in_item_reg),
        .state  (pad_state),
        .cfg    (cfg_reg),
        .result (result),
        .upd    (pad_upd)
    );

    // Every event comes with a threshold write
    a_event_writes_threshold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.event_kind != tpeq_pkg::KIND_NONE) |-> m_data.threshold_write)
        else $error("event without threshold write");

    // No threshold write means a zero threshold value
    a_idle_threshold_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.threshold_write) |-> (m_data.threshold_value == '0))
        else $error("threshold value without write");

    // A pad out of range gives an empty result
    a_bad_pad_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && ({1'b0, in_item_reg.pad_index} >= 5'(tpeq_pkg::NUM_PADS)))
        |=> (m_valid && m_data.event_kind == tpeq_pkg::KIND_NONE && !m_data.threshold_write))
        else $error("out of range pad gave a result");

    // An accepted item is held in the input register
    a_accept_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> in_valid_reg)
        else $error("accepted item lost");

endmodule
